>>> src/bfpa_pkg.sv
// Package for the best-fit partition allocator: sizes, codes, word types
// and the priority-to-units mapping. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfpa_pkg;

   // Table geometry
   localparam int NUM_SLOTS  = 20;
   localparam int OWNER_BITS = 16;
   localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // Field widths
   localparam int COUNT_BITS       = 5;
   localparam int PRIO_BITS        = 4;
   localparam int SLOT_FIELD_BITS  = 5;
   localparam int UNITS_BITS       = 2;
   localparam int FREED_FIELD_BITS = 5;

   // Width for comparing a slot index against region bounds
   localparam int CMP_BITS = ((SLOT_BITS > COUNT_BITS) ? SLOT_BITS : COUNT_BITS) + 1;

   // Register reset values
   localparam logic [COUNT_BITS-1:0] LARGE_COUNT_RESET  = 5'd4;
   localparam logic [COUNT_BITS-1:0] MEDIUM_COUNT_RESET = 5'd4;

   // Partition sizes in units
   localparam logic [UNITS_BITS-1:0] UNITS_LARGE  = 2'd3;
   localparam logic [UNITS_BITS-1:0] UNITS_MEDIUM = 2'd2;
   localparam logic [UNITS_BITS-1:0] UNITS_SMALL  = 2'd1;

   // Priority thresholds
   localparam logic [PRIO_BITS-1:0] PRIO_LARGE_MAX = 4'd2;
   localparam logic [PRIO_BITS-1:0] PRIO_MEDIUM    = 4'd3;

   typedef enum logic {
      OP_ADMIT   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_ADMITTED = 2'd0,
      STATUS_NO_FIT   = 2'd1,
      STATUS_RELEASED = 2'd2,
      STATUS_NONE     = 2'd3
   } status_type;

   typedef enum logic {
      CSR_LARGE_COUNT  = 1'b0,
      CSR_MEDIUM_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      op_type                operation;
      logic [OWNER_BITS-1:0] owner_id;
      logic [PRIO_BITS-1:0]  priority_req;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [SLOT_FIELD_BITS-1:0]  slot_index;
      logic [UNITS_BITS-1:0]       units_needed;
      logic [FREED_FIELD_BITS-1:0] freed_count;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture the request word
      logic exec;   // search/update the table and register the result
   } ctrl_cmd_type;

   // Map an admit priority to the units it needs
   function automatic logic [UNITS_BITS-1:0] units_for_priority(
      input logic [PRIO_BITS-1:0] prio
   );
      logic [UNITS_BITS-1:0] units;
      if (prio <= PRIO_LARGE_MAX) begin
         units = UNITS_LARGE;
      end else if (prio == PRIO_MEDIUM) begin
         units = UNITS_MEDIUM;
      end else begin
         units = UNITS_SMALL;
      end
      return units;
   endfunction

endpackage

`default_nettype wire

>>> src/bfpa_ctrl.sv
// Controller for the best-fit partition allocator: two-state sequencer
// that issues load and exec commands. Depends on bfpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfpa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       rsp_valid,
   output bfpa_pkg::ctrl_cmd_type     cmd
);

   bfpa_pkg::ctrl_state_type state_ff;
   bfpa_pkg::ctrl_state_type state_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfpa_pkg::ST_IDLE: begin
            if (start) begin
               state_in = bfpa_pkg::ST_EXEC;
            end
         end
         bfpa_pkg::ST_EXEC: begin
            state_in = bfpa_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfpa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      busy     = 1'b0;
      cmd.load = 1'b0;
      cmd.exec = 1'b0;
      unique case (state_ff)
         bfpa_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         bfpa_pkg::ST_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Strobe the result word the cycle after exec
   assign rsp_valid_in = cmd.exec;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfpa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Assertions
   a_exec_one_cycle : assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("exec state held longer than one cycle");

   a_strobe_after_exec : assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("no result strobe after exec");

   a_accept_enters_exec : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start exec");

endmodule

`default_nettype wire

>>> src/bfpa_datapath.sv
// Datapath for the best-fit partition allocator: size registers, partition
// table, best-fit search, release match and result register. Depends on bfpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfpa_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bfpa_pkg::ctrl_cmd_type                cmd,
   input  wire bfpa_pkg::req_type                     req_data,
   input  wire logic                                  csr_we,
   input  wire bfpa_pkg::csr_index_type               csr_index,
   input  wire logic [bfpa_pkg::COUNT_BITS-1:0]       csr_wdata,
   output bfpa_pkg::rsp_type                          rsp_data
);

   logic [bfpa_pkg::COUNT_BITS-1:0]  large_count_ff;
   logic [bfpa_pkg::COUNT_BITS-1:0]  medium_count_ff;
   bfpa_pkg::req_type                req_ff;
   bfpa_pkg::rsp_type                rsp_ff;
   bfpa_pkg::rsp_type                rsp_in;
   logic [bfpa_pkg::NUM_SLOTS-1:0]   slot_free_ff;
   logic [bfpa_pkg::NUM_SLOTS-1:0]   slot_free_in;
   logic [bfpa_pkg::OWNER_BITS-1:0]  slot_owner_ff [bfpa_pkg::NUM_SLOTS];

   logic [bfpa_pkg::CMP_BITS-1:0]    large_end;
   logic [bfpa_pkg::CMP_BITS-1:0]    medium_end;
   logic [bfpa_pkg::NUM_SLOTS-1:0]   mask_large;
   logic [bfpa_pkg::NUM_SLOTS-1:0]   mask_medium;
   logic [bfpa_pkg::NUM_SLOTS-1:0]   mask_small;
   logic [bfpa_pkg::NUM_SLOTS-1:0]   mask_pick;
   logic [bfpa_pkg::NUM_SLOTS-1:0]   release_match;
   logic [bfpa_pkg::UNITS_BITS-1:0]  need;
   logic [bfpa_pkg::SLOT_BITS-1:0]   pick;
   logic                             found;
   logic                             admit_hit;
   logic [bfpa_pkg::FREED_FIELD_BITS-1:0] freed;

   // Index of the lowest set bit of a slot mask
   function automatic logic [bfpa_pkg::SLOT_BITS-1:0] lowest_index(
      input logic [bfpa_pkg::NUM_SLOTS-1:0] mask
   );
      logic [bfpa_pkg::NUM_SLOTS-1:0] lone;
      logic [bfpa_pkg::SLOT_BITS-1:0] idx;
      lone = mask & (~mask + 1'b1);
      idx  = '0;
      for (int i = 0; i < bfpa_pkg::NUM_SLOTS; i++) begin
         if (lone[i]) begin
            idx = idx | bfpa_pkg::SLOT_BITS'(i);
         end
      end
      return idx;
   endfunction

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         large_count_ff  <= bfpa_pkg::LARGE_COUNT_RESET;
         medium_count_ff <= bfpa_pkg::MEDIUM_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bfpa_pkg::CSR_LARGE_COUNT:  large_count_ff  <= csr_wdata;
            bfpa_pkg::CSR_MEDIUM_COUNT: medium_count_ff <= csr_wdata;
            default: large_count_ff <= large_count_ff;
         endcase
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Classify every free partition by size
   assign large_end  = bfpa_pkg::CMP_BITS'(large_count_ff);
   assign medium_end = bfpa_pkg::CMP_BITS'(large_count_ff)
                     + bfpa_pkg::CMP_BITS'(medium_count_ff);

   always_comb begin
      for (int i = 0; i < bfpa_pkg::NUM_SLOTS; i++) begin
         mask_large[i]    = slot_free_ff[i] && (bfpa_pkg::CMP_BITS'(i) < large_end);
         mask_medium[i]   = slot_free_ff[i] && (bfpa_pkg::CMP_BITS'(i) >= large_end)
                          && (bfpa_pkg::CMP_BITS'(i) < medium_end);
         mask_small[i]    = slot_free_ff[i] && (bfpa_pkg::CMP_BITS'(i) >= large_end)
                          && (bfpa_pkg::CMP_BITS'(i) >= medium_end);
         release_match[i] = !slot_free_ff[i] && (slot_owner_ff[i] == req_ff.owner_id);
      end
   end

   // Best fit: smallest size class that holds the need, lowest index first
   assign need = bfpa_pkg::units_for_priority(req_ff.priority_req);

   always_comb begin
      found     = 1'b1;
      mask_pick = '0;
      if ((need == bfpa_pkg::UNITS_SMALL) && (mask_small != '0)) begin
         mask_pick = mask_small;
      end else if ((need != bfpa_pkg::UNITS_LARGE) && (mask_medium != '0)) begin
         mask_pick = mask_medium;
      end else if (mask_large != '0) begin
         mask_pick = mask_large;
      end else begin
         found = 1'b0;
      end
   end

   assign pick      = lowest_index(mask_pick);
   assign admit_hit = cmd.exec && (req_ff.operation == bfpa_pkg::OP_ADMIT) && found;
   assign freed     = bfpa_pkg::FREED_FIELD_BITS'($countones(release_match));

   // Next free flags
   always_comb begin
      slot_free_in = slot_free_ff;
      if (cmd.exec) begin
         if (req_ff.operation == bfpa_pkg::OP_RELEASE) begin
            slot_free_in = slot_free_ff | release_match;
         end else if (found) begin
            slot_free_in[pick] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_free_ff <= '1;
      end else begin
         slot_free_ff <= slot_free_in;
      end
   end

   // Record the owner of an admitted partition
   always_ff @(posedge clock) begin
      if (admit_hit) begin
         slot_owner_ff[pick] <= req_ff.owner_id;
      end
   end

   // Build the result word
   always_comb begin
      rsp_in = '0;
      if (req_ff.operation == bfpa_pkg::OP_ADMIT) begin
         rsp_in.units_needed = need;
         if (found) begin
            rsp_in.status     = bfpa_pkg::STATUS_ADMITTED;
            rsp_in.slot_index = bfpa_pkg::SLOT_FIELD_BITS'(pick);
         end else begin
            rsp_in.status = bfpa_pkg::STATUS_NO_FIT;
         end
      end else begin
         rsp_in.freed_count = freed;
         rsp_in.status      = (release_match != '0) ? bfpa_pkg::STATUS_RELEASED
                                                     : bfpa_pkg::STATUS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // Assertions
   a_admit_takes_one : assert property (@(posedge clock) disable iff (reset)
      admit_hit |=> ($countones(slot_free_ff) + 1 == $past($countones(slot_free_ff))))
      else $error("admit did not take exactly one partition");

   a_release_frees : assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (req_ff.operation == bfpa_pkg::OP_RELEASE))
      |=> ($countones(slot_free_ff)
           == $past($countones(slot_free_ff)) + int'(rsp_ff.freed_count)))
      else $error("release count does not match freed partitions");

   a_table_idle_stable : assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(slot_free_ff))
      else $error("free flags changed outside exec");

endmodule

`default_nettype wire

>>> src/best_fit_partition_allocator_top.sv
// Top level of the best-fit partition allocator: joins the controller and
// the datapath. Depends on bfpa_pkg, bfpa_ctrl and bfpa_datapath.
//
//   channel   handshake           word
//   --------  ------------------  ------------------------------
//   request   start / busy        req_data  (bfpa_pkg::req_type)
//   result    rsp_valid strobe    rsp_data  (bfpa_pkg::rsp_type)
//   config    csr_we              csr_index, csr_wdata
//
// Each word is first captured; then, in the exec state, the single
// compare-and-encode over the partition table picks or frees and updates it.
// busy is high during the exec state; a new word can be taken the cycle after.
// The result strobes for one cycle after the update; the receiver cannot stall.
// Synchronous reset marks every partition free and loads both size counts with 4.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_partition_allocator_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire bfpa_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   output bfpa_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire bfpa_pkg::csr_index_type           csr_index,
   input  wire logic [bfpa_pkg::COUNT_BITS-1:0]   csr_wdata
);

   bfpa_pkg::ctrl_cmd_type cmd;

   // Sequencer
   bfpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Table and search
   bfpa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
